// ===== hw/rtl/kst_pkg.sv =====
// Shared types, constants and scan-code tables of the keyboard scancode translator.
`timescale 1ns / 1ps

package kst_pkg;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_CHAR    = 3'd0,
    KIND_KB_BYTE = 3'd1,
    KIND_FOCUS   = 3'd2,
    KIND_RAISE   = 3'd3,
    KIND_BREAK   = 3'd4
  } kind_e;

  // One result item.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic       last;
  } result_t;

  // Keyboard commands and replies.
  localparam logic [7:0] LED_CMD     = 8'hED;
  localparam logic [7:0] ACK_BYTE    = 8'hFA;
  localparam logic [7:0] RESEND_BYTE = 8'hFE;

  // Scan codes with a special meaning.
  localparam logic [7:0] SC_TAB        = 8'h0F;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] SC_NUM        = 8'h45;
  localparam logic [7:0] SC_SCROLL     = 8'h46;
  localparam logic [7:0] SC_F1         = 8'h3B;
  localparam logic [7:0] SC_F11        = 8'h57;

  // Character range that gets case folding.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Unshifted Japanese-layout map for codes below 0x80.
  function automatic logic [7:0] plain_char(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'h02: ch = 8'h31;
      7'h03: ch = 8'h32;
      7'h04: ch = 8'h33;
      7'h05: ch = 8'h34;
      7'h06: ch = 8'h35;
      7'h07: ch = 8'h36;
      7'h08: ch = 8'h37;
      7'h09: ch = 8'h38;
      7'h0A: ch = 8'h39;
      7'h0B: ch = 8'h30;
      7'h0C: ch = 8'h2D;
      7'h0D: ch = 8'h5E;
      7'h0E: ch = 8'h08;
      7'h10: ch = 8'h51;
      7'h11: ch = 8'h57;
      7'h12: ch = 8'h45;
      7'h13: ch = 8'h52;
      7'h14: ch = 8'h54;
      7'h15: ch = 8'h59;
      7'h16: ch = 8'h55;
      7'h17: ch = 8'h49;
      7'h18: ch = 8'h4F;
      7'h19: ch = 8'h50;
      7'h1A: ch = 8'h40;
      7'h1B: ch = 8'h5B;
      7'h1C: ch = 8'h0A;
      7'h1E: ch = 8'h41;
      7'h1F: ch = 8'h53;
      7'h20: ch = 8'h44;
      7'h21: ch = 8'h46;
      7'h22: ch = 8'h47;
      7'h23: ch = 8'h48;
      7'h24: ch = 8'h4A;
      7'h25: ch = 8'h4B;
      7'h26: ch = 8'h4C;
      7'h27: ch = 8'h3B;
      7'h28: ch = 8'h3A;
      7'h2B: ch = 8'h5D;
      7'h2C: ch = 8'h5A;
      7'h2D: ch = 8'h58;
      7'h2E: ch = 8'h43;
      7'h2F: ch = 8'h56;
      7'h30: ch = 8'h42;
      7'h31: ch = 8'h4E;
      7'h32: ch = 8'h4D;
      7'h33: ch = 8'h2C;
      7'h34: ch = 8'h2E;
      7'h35: ch = 8'h2F;
      7'h37: ch = 8'h2A;
      7'h39: ch = 8'h20;
      7'h47: ch = 8'h37;
      7'h48: ch = 8'h38;
      7'h49: ch = 8'h39;
      7'h4A: ch = 8'h2D;
      7'h4B: ch = 8'h34;
      7'h4C: ch = 8'h35;
      7'h4D: ch = 8'h36;
      7'h4E: ch = 8'h2B;
      7'h4F: ch = 8'h31;
      7'h50: ch = 8'h32;
      7'h51: ch = 8'h33;
      7'h52: ch = 8'h30;
      7'h53: ch = 8'h2E;
      7'h73: ch = 8'h5C;
      7'h7D: ch = 8'h5C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Shifted map: differs from the unshifted map only on a few keys.
  function automatic logic [7:0] shifted_char(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'h02: ch = 8'h21;
      7'h03: ch = 8'h22;
      7'h04: ch = 8'h23;
      7'h05: ch = 8'h24;
      7'h06: ch = 8'h25;
      7'h07: ch = 8'h26;
      7'h08: ch = 8'h27;
      7'h09: ch = 8'h28;
      7'h0A: ch = 8'h29;
      7'h0B: ch = 8'h7E;
      7'h0C: ch = 8'h3D;
      7'h0D: ch = 8'h7E;
      7'h1A: ch = 8'h60;
      7'h1B: ch = 8'h7B;
      7'h27: ch = 8'h2B;
      7'h28: ch = 8'h2A;
      7'h2B: ch = 8'h7D;
      7'h33: ch = 8'h3C;
      7'h34: ch = 8'h3E;
      7'h35: ch = 8'h3F;
      7'h73: ch = 8'h5F;
      7'h7D: ch = 8'h7C;
      default: ch = plain_char(code);
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/kst_out_buf.sv =====
// Two-entry result buffer that decouples the translator from the output channel.
`timescale 1ns / 1ps

module kst_out_buf
  import kst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [1:0] num_i,
  input  result_t    ent0_i,
  input  result_t    ent1_i,
  output logic [1:0] free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    head_o
);

  logic [1:0] cnt_q, cnt_d;
  logic [1:0] cnt_after;
  result_t    slot0_q, slot0_d;
  result_t    slot1_q, slot1_d;
  logic       deq;

  assign out_valid_o = (cnt_q != 2'd0);
  assign head_o      = slot0_q;
  assign deq         = out_valid_o & out_ready_i;
  assign cnt_after   = cnt_q - {1'b0, deq};
  assign free_o      = 2'd2 - cnt_after;

  // Shift out the taken item, then append the new results behind what is left.
  // A push that carries no results leaves the slots untouched.
  always_comb begin
    slot0_d = deq ? slot1_q : slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_after;
    if (push_i && (num_i != 2'd0)) begin
      if (cnt_after == 2'd0) begin
        slot0_d = ent0_i;
        slot1_d = ent1_i;
      end else begin
        slot1_d = ent0_i;
      end
      cnt_d = cnt_after + num_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  // The buffer never holds more than two items.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  // New results are only pushed when they fit.
  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> num_i <= free_o)
    else $error("result buffer overflow");

endmodule

// ===== hw/rtl/keyboard_scancode_translator.sv =====
// Top level of the keyboard scancode translator with its command queue memory.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    action_i, scan_byte_i
//   out      output     out_valid_o / out_ready_i  kind_o, value_o, last_o
//   cfg      input      cfg_we_i                   cfg_wdata_i
//
// Input ready drops after each accept: the command memory has one write port and an item
// may push two bytes, one in the accept cycle and one in the next.
// The popped command byte comes from the registered memory read of the accept cycle.
// Results leave through a two-entry buffer, one per cycle when out_ready_i is high; a stalled output
// holds the item in the second stage and input ready stays low meanwhile.
// Reset clears all control state; the memory itself needs no clearing pass.
`timescale 1ns / 1ps

module keyboard_scancode_translator
  import kst_pkg::*;
#(
  parameter int CMD_QUEUE_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] value_o,
  output logic       last_o
);

  localparam int HW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);
  localparam int AW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(CMD_QUEUE_DEPTH);
  localparam logic [AW-1:0] DEPTH_A = AW'(CMD_QUEUE_DEPTH);
  localparam logic [HW-1:0] LAST_IDX = HW'(CMD_QUEUE_DEPTH - 1);

  // Architectural state.
  logic [2:0]    boot_q;
  logic [1:0]    shift_q, shift_d;
  logic [2:0]    led_q, led_d;
  logic          pend_valid_q, pend_valid_d;
  logic [7:0]    pend_byte_q;
  logic [HW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;

  // Command queue memory.
  logic [7:0]    mem [CMD_QUEUE_DEPTH];
  logic [7:0]    rd_q;
  logic          wr_en;
  logic [HW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          wr2_q;
  logic [HW-1:0] wr2_addr_q;
  logic [7:0]    wr2_data_q;

  // Second stage: results of the accepted item.
  logic       s1_valid_q;
  logic       s1_ev_q;
  kind_e      s1_ev_kind_q;
  logic [7:0] s1_ev_value_q;
  logic       s1_kb_q;
  logic       s1_kb_mem_q;
  logic       s1_pop_q;
  logic [7:0] s1_kb_value_q;

  // Combinational decode of the incoming item.
  logic          acc;
  logic          shift_any;
  logic [7:0]    ch;
  logic          ev;
  kind_e         ev_kind;
  logic [7:0]    ev_value;
  logic          push_req;
  logic          pend_after;
  logic          resend;
  logic          ok1, ok2, pop;
  logic [CW-1:0] count1, count2;
  logic [AW-1:0] sum1, sum2;
  logic [HW-1:0] addr1;
  logic [7:0]    push2_data;

  // Output side.
  logic [7:0] kb_value;
  logic [1:0] s1_num;
  logic [1:0] buf_free;
  logic       move;
  result_t    ev_ent, kb_ent, ent0;
  result_t    head;

  assign in_ready_o = !s1_valid_q;
  assign acc        = in_valid_i & in_ready_o;

  // Translate the byte, update lock and shift state, and plan queue traffic.
  always_comb begin
    shift_any = (shift_q != 2'b00);
    ch        = 8'h00;
    if (!scan_byte_i[7]) begin
      ch = shift_any ? shifted_char(scan_byte_i[6:0]) : plain_char(scan_byte_i[6:0]);
    end
    if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z && led_q[2] == shift_any) begin
      ch = ch + CASE_OFFSET;
    end

    ev         = 1'b0;
    ev_kind    = KIND_CHAR;
    ev_value   = ch;
    shift_d    = shift_q;
    led_d      = led_q;
    push_req   = 1'b0;
    pend_after = pend_valid_q;
    resend     = 1'b0;

    if (action_i) begin
      led_d    = boot_q;
      push_req = 1'b1;
    end else begin
      ev = (ch != 8'h00);
      if (scan_byte_i == SC_TAB) begin
        ev       = 1'b1;
        ev_kind  = KIND_FOCUS;
        ev_value = 8'h00;
      end
      if (scan_byte_i == SC_F11) begin
        ev       = 1'b1;
        ev_kind  = KIND_RAISE;
        ev_value = 8'h00;
      end
      if (scan_byte_i == SC_F1 && shift_any) begin
        ev       = 1'b1;
        ev_kind  = KIND_BREAK;
        ev_value = 8'h00;
      end
      unique case (scan_byte_i)
        SC_LSHIFT:     shift_d = shift_q | 2'b01;
        SC_RSHIFT:     shift_d = shift_q | 2'b10;
        SC_LSHIFT_REL: shift_d = shift_q & 2'b10;
        SC_RSHIFT_REL: shift_d = shift_q & 2'b01;
        SC_CAPS: begin
          led_d    = led_q ^ 3'b100;
          push_req = 1'b1;
        end
        SC_NUM: begin
          led_d    = led_q ^ 3'b010;
          push_req = 1'b1;
        end
        SC_SCROLL: begin
          led_d    = led_q ^ 3'b001;
          push_req = 1'b1;
        end
        ACK_BYTE:    pend_after = 1'b0;
        RESEND_BYTE: resend     = pend_valid_q;
        default: ;
      endcase
    end

    // Up to two pushes; each is dropped when the queue is full.
    ok1    = push_req && (count_q < DEPTH_C);
    count1 = count_q + CW'(ok1);
    ok2    = push_req && (count1 < DEPTH_C);
    count2 = count1 + CW'(ok2);

    sum1 = AW'(head_q) + AW'(count_q);
    if (sum1 >= DEPTH_A) begin
      sum1 = sum1 - DEPTH_A;
    end
    sum2 = AW'(head_q) + AW'(count1);
    if (sum2 >= DEPTH_A) begin
      sum2 = sum2 - DEPTH_A;
    end
    addr1      = sum1[HW-1:0];
    push2_data = {5'b00000, led_d};

    // Send the next queued byte when nothing awaits an ack.
    pop          = !pend_after && (count2 != '0);
    count_d      = count2 - CW'(pop);
    head_d       = pop ? ((head_q == LAST_IDX) ? '0 : head_q + 1'b1) : head_q;
    pend_valid_d = pend_after | pop;
  end

  // Single memory write port: first push at accept, second push in the cycle after.
  assign wr_en   = (acc & ok1) | wr2_q;
  assign wr_addr = wr2_q ? wr2_addr_q : addr1;
  assign wr_data = wr2_q ? wr2_data_q : LED_CMD;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (acc) begin
      rd_q <= mem[head_q];
    end
  end

  // Control and architectural state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_q       <= 3'b000;
      shift_q      <= 2'b00;
      led_q        <= 3'b000;
      pend_valid_q <= 1'b0;
      pend_byte_q  <= 8'h00;
      head_q       <= '0;
      count_q      <= '0;
      wr2_q        <= 1'b0;
      s1_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        boot_q <= cfg_wdata_i;
      end
      wr2_q <= acc & ok2;
      if (acc) begin
        shift_q      <= shift_d;
        led_q        <= led_d;
        pend_valid_q <= pend_valid_d;
        head_q       <= head_d;
        count_q      <= count_d;
        s1_valid_q   <= 1'b1;
      end else if (move) begin
        s1_valid_q <= 1'b0;
      end
      // The popped byte becomes the byte awaiting an ack.
      if (s1_valid_q && s1_pop_q) begin
        pend_byte_q <= kb_value;
      end
    end
  end

  // Second stage payload.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      wr2_addr_q    <= sum2[HW-1:0];
      wr2_data_q    <= push2_data;
      s1_ev_q       <= ev;
      s1_ev_kind_q  <= ev_kind;
      s1_ev_value_q <= ev_value;
      s1_kb_q       <= resend | pop;
      s1_kb_mem_q   <= pop && (count_q != '0);
      s1_pop_q      <= pop;
      s1_kb_value_q <= resend ? pend_byte_q : LED_CMD;
    end
  end

  // Assemble the item's results and hand them to the output buffer.
  assign kb_value = s1_kb_mem_q ? rd_q : s1_kb_value_q;
  assign s1_num   = {1'b0, s1_ev_q} + {1'b0, s1_kb_q};
  assign move     = s1_valid_q && (s1_num <= buf_free);

  always_comb begin
    ev_ent.kind  = s1_ev_kind_q;
    ev_ent.value = s1_ev_value_q;
    ev_ent.last  = !s1_kb_q;
    kb_ent.kind  = KIND_KB_BYTE;
    kb_ent.value = kb_value;
    kb_ent.last  = 1'b1;
    ent0         = s1_ev_q ? ev_ent : kb_ent;
  end

  kst_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (move),
    .num_i       (s1_num),
    .ent0_i      (ent0),
    .ent1_i      (kb_ent),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign kind_o  = head.kind;
  assign value_o = head.value;
  assign last_o  = head.last;

  // The queue fill never exceeds its depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("command queue count exceeds depth");

  // An item is never accepted in the cycle after another one.
  a_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> !in_ready_o)
    else $error("item accepted while second push in progress");

  // The second push never collides with a first push on the write port.
  a_wr_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr2_q |-> !acc)
    else $error("command memory write port conflict");

  // A popped byte always leaves a byte awaiting an ack.
  a_pop_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_pop_q) |-> pend_valid_q)
    else $error("popped byte without pending state");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the keyboard scancode translator.
`timescale 1ns / 1ps

module tb_top;
  import kst_pkg::*;

  localparam int FIFO_DEPTH    = 32;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int SESSION_ITEMS = 250;
  localparam int REPORT_LIMIT  = 10;

  // One keyboard-side item: a start request or a raw scan byte.
  typedef struct packed {
    logic       start;
    logic [7:0] code;
  } key_item_t;

  // Japanese-layout character maps, entry 0 in the leftmost byte of each row.
  localparam logic [0:127][7:0] PLAIN_MAP = {
    128'h0000_3132_3334_3536_3738_3930_2D5E_0800,
    128'h5157_4552_5459_5549_4F50_405B_0A00_4153,
    128'h4446_4748_4A4B_4C3B_3A00_005D_5A58_4356,
    128'h424E_4D2C_2E2F_002A_0020_0000_0000_0000,
    128'h0000_0000_0000_0037_3839_2D34_3536_2B31,
    128'h3233_302E_0000_0000_0000_0000_0000_0000,
    128'h0,
    128'h0000_005C_0000_0000_0000_0000_005C_0000
  };
  localparam logic [0:127][7:0] SHIFTED_MAP = {
    128'h0000_2122_2324_2526_2728_297E_3D7E_0800,
    128'h5157_4552_5459_5549_4F50_607B_0A00_4153,
    128'h4446_4748_4A4B_4C2B_2A00_007D_5A58_4356,
    128'h424E_4D3C_3E3F_002A_0020_0000_0000_0000,
    128'h0000_0000_0000_0037_3839_2D34_3536_2B31,
    128'h3233_302E_0000_0000_0000_0000_0000_0000,
    128'h0,
    128'h0000_005F_0000_0000_0000_0000_007C_0000
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [2:0] cfg_wdata_i = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic       action_i    = 1'b0;
  logic [7:0] scan_byte_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] kind_o;
  logic [7:0] value_o;
  logic       last_o;

  // Translator state as the checker tracks it.
  logic [2:0] boot_locks   = '0;
  logic [1:0] held_shift   = '0;
  logic [2:0] led_state    = '0;
  logic       awaiting_ack = 1'b0;
  logic [7:0] byte_on_wire = '0;
  logic [7:0] cmd_fifo [FIFO_DEPTH];
  logic [4:0] cmd_head     = '0;
  int         cmd_count    = 0;

  key_item_t key_items [$];
  result_t   expected_results [$];
  int        items_queued    = 0;
  int        items_accepted  = 0;
  int        results_checked = 0;
  int        mismatches      = 0;
  int        lock_settings   = 0;
  int        cycle_count     = 0;
  int        quiet_cycles    = 0;

  keyboard_scancode_translator #(
    .CMD_QUEUE_DEPTH(FIFO_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .scan_byte_i(scan_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .value_o    (value_o),
    .last_o     (last_o)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Random back-pressure on either side, switched off for one long stretch in every window.
  function automatic bit hold_back();
    if ((cycle_count % 6000) >= 4500) return 1'b0;
    return $urandom_range(0, 99) < 34;
  endfunction

  function automatic void expect_result(kind_e kind, logic [7:0] value);
    result_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = 1'b0;
    expected_results.push_back(r);
  endfunction

  // A byte offered to a full command queue is lost.
  function automatic void push_command(logic [7:0] b);
    if (cmd_count < FIFO_DEPTH) begin
      cmd_fifo[(cmd_head + cmd_count) % FIFO_DEPTH] = b;
      cmd_count++;
    end
  endfunction

  function automatic void queue_led_sync();
    push_command(LED_CMD);
    push_command({5'b0, led_state});
  endfunction

  // Works out the results of one accepted item and updates the tracked state.
  function automatic void predict_translation(logic start, logic [7:0] code);
    int         first;
    logic [7:0] ch;
    first = expected_results.size();
    if (start) begin
      led_state = boot_locks;
      queue_led_sync();
    end else begin
      // Only codes below 0x80 map to a character.
      ch = 8'h00;
      if (!code[7]) begin
        ch = (held_shift != 2'b00) ? SHIFTED_MAP[code[6:0]] : PLAIN_MAP[code[6:0]];
      end
      // A letter stays upper case only when caps lock and shift disagree.
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z && led_state[2] == (held_shift != 2'b00)) begin
        ch = ch + CASE_OFFSET;
      end
      if (ch != 8'h00) expect_result(KIND_CHAR, ch);
      case (code)
        SC_TAB:        expect_result(KIND_FOCUS, 8'h00);
        SC_LSHIFT:     held_shift[0] = 1'b1;
        SC_RSHIFT:     held_shift[1] = 1'b1;
        SC_LSHIFT_REL: held_shift[0] = 1'b0;
        SC_RSHIFT_REL: held_shift[1] = 1'b0;
        SC_CAPS: begin
          led_state[2] = ~led_state[2];
          queue_led_sync();
        end
        SC_NUM: begin
          led_state[1] = ~led_state[1];
          queue_led_sync();
        end
        SC_SCROLL: begin
          led_state[0] = ~led_state[0];
          queue_led_sync();
        end
        SC_F1: begin
          if (held_shift != 2'b00) expect_result(KIND_BREAK, 8'h00);
        end
        SC_F11:        expect_result(KIND_RAISE, 8'h00);
        ACK_BYTE:      awaiting_ack = 1'b0;
        RESEND_BYTE: begin
          if (awaiting_ack) expect_result(KIND_KB_BYTE, byte_on_wire);
        end
        default: ;
      endcase
    end
    // With nothing awaiting an ack, the next queued command goes out.
    if (!awaiting_ack && cmd_count > 0) begin
      byte_on_wire = cmd_fifo[cmd_head];
      cmd_head     = cmd_head + 1'b1;
      cmd_count--;
      awaiting_ack = 1'b1;
      expect_result(KIND_KB_BYTE, byte_on_wire);
    end
    if (expected_results.size() > first) begin
      expected_results[expected_results.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("tb_top: mismatch: %s", msg);
  endfunction

  function automatic void send_key(logic [7:0] code);
    key_items.push_back(key_item_t'{start: 1'b0, code: code});
    items_queued++;
  endfunction

  // The scan byte is meaningless on a start, so it carries noise.
  function automatic void send_start();
    key_items.push_back(key_item_t'{start: 1'b1, code: 8'($urandom_range(0, 255))});
    items_queued++;
  endfunction

  function automatic logic [7:0] any_lock_key();
    case ($urandom_range(0, 2))
      0:       return SC_CAPS;
      1:       return SC_NUM;
      default: return SC_SCROLL;
    endcase
  endfunction

  // Mostly realistic keyboard traffic: typing, lock keys answered by acks, starts and
  // bursts that overflow the command queue, with some raw noise mixed in.
  task automatic random_session(int count);
    int target;
    int pick;
    int shifts;
    target = items_queued + count;
    while (items_queued < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        shifts = $urandom_range(0, 3);
        if (shifts[0]) send_key(SC_LSHIFT);
        if (shifts[1]) send_key(SC_RSHIFT);
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1)) send_key(8'($urandom_range(8'h10, 8'h32)));
          else send_key(8'($urandom_range(0, 8'h7F)));
        end
        if (shifts[0]) send_key(SC_LSHIFT_REL);
        if (shifts[1]) send_key(SC_RSHIFT_REL);
      end else if (pick < 50) begin
        send_key(any_lock_key());
        repeat (2) begin
          if ($urandom_range(0, 99) < 20) send_key(RESEND_BYTE);
          send_key(ACK_BYTE);
        end
      end else if (pick < 58) begin
        send_key($urandom_range(0, 1) ? ACK_BYTE : RESEND_BYTE);
      end else if (pick < 64) begin
        send_start();
        repeat (2) send_key(ACK_BYTE);
      end else if (pick < 70) begin
        // Lock presses without acks fill the queue until bytes get dropped.
        repeat ($urandom_range(16, 20)) send_key(any_lock_key());
        repeat ($urandom_range(30, 44)) send_key(ACK_BYTE);
      end else if (pick < 82) begin
        case ($urandom_range(0, 3))
          0: send_key(SC_TAB);
          1: send_key(SC_F11);
          2: send_key(SC_F1);
          default: begin
            send_key(SC_RSHIFT);
            send_key(SC_F1);
            send_key(SC_RSHIFT_REL);
          end
        endcase
      end else begin
        send_key(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Hold until every item is accepted and every result is in, then let the block settle.
  task automatic wait_for_drain();
    while (!(items_accepted == items_queued && expected_results.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_lock_setting(logic [2:0] locks);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= locks;
    boot_locks = locks;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lock_settings++;
  endtask

  // Input driver: takes accepted items into the prediction and presents the next one.
  always @(posedge clk_i) begin
    key_item_t item;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_translation(action_i, scan_byte_i);
        items_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (key_items.size() > 0 && !hold_back()) begin
          item = key_items.pop_front();
          in_valid_i  <= 1'b1;
          action_i    <= item.start;
          scan_byte_i <= item.code;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each accepted result must match the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d value %h last %b",
                                    kind_o, value_o, last_o));
        end else begin
          want = expected_results.pop_front();
          if (want.kind != kind_o || want.value != value_o || want.last != last_o) begin
            report_mismatch($sformatf(
              "result %0d: kind %0d/%0d value %h/%h last %b/%b (expected/actual)",
              results_checked, want.kind, kind_o, want.value, value_o, want.last, last_o));
          end
        end
      end
      out_ready_i <= !hold_back();
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: no handshake for %0d cycles, %0d results still expected",
                 STALL_LIMIT, expected_results.size());
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Stimulus sequence: a directed opening, then random sessions under several lock settings.
  initial begin
    logic [2:0] settings [6];
    settings = '{3'b000, 3'b111, 3'b010, 3'b101,
                 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_lock_setting(3'b110);

    // Start sync, a resend of the pending byte, acks and replies with nothing pending.
    send_start();
    send_key(RESEND_BYTE);
    send_key(ACK_BYTE);
    send_key(ACK_BYTE);
    send_key(ACK_BYTE);
    send_key(RESEND_BYTE);
    // Code extremes, both below 0x80 and from 0x80 up.
    send_key(8'h00);
    send_key(8'h7F);
    send_key(8'h80);
    send_key(8'hFF);
    // Letters and symbols under caps lock and each shift key.
    send_key(8'h1E);
    send_key(SC_LSHIFT);
    send_key(8'h1E);
    send_key(8'h02);
    send_key(SC_F1);
    send_key(8'h7D);
    send_key(SC_RSHIFT);
    send_key(SC_LSHIFT_REL);
    send_key(8'h73);
    send_key(SC_RSHIFT_REL);
    send_key(SC_F1);
    // Events and lock toggles.
    send_key(SC_TAB);
    send_key(SC_F11);
    send_key(SC_CAPS);
    send_key(SC_NUM);
    send_key(SC_SCROLL);

    foreach (settings[i]) begin
      wait_for_drain();
      write_lock_setting(settings[i]);
      send_start();
      random_session(SESSION_ITEMS);
    end
    wait_for_drain();

    $display("tb_top: %0d items (scan bytes and starts) accepted under %0d lock settings",
             items_accepted, lock_settings);
    $display("tb_top: %0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== keyboard_scancode_translator.f =====
hw/rtl/kst_pkg.sv
hw/rtl/kst_out_buf.sv
hw/rtl/keyboard_scancode_translator.sv
test/tb_top.sv
